FILE: rtl/natural_selection_run_generator_defines.svh
// Assertion macros for the RTL.
`ifndef NATURAL_SELECTION_RUN_GENERATOR_DEFINES_SVH
`define NATURAL_SELECTION_RUN_GENERATOR_DEFINES_SVH

// Same-cycle implication.
`define NSRG_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nsrg assertion failed");

// Next-cycle implication.
`define NSRG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nsrg assertion failed");

`endif

FILE: rtl/nsrg_pkg.sv
package nsrg_pkg;

   localparam int MEM_DEPTH_DEF    = 16;
   localparam int RES_DEPTH_DEF    = 16;
   localparam int PAYLOAD_BITS_DEF = 32;

   localparam int KEY_W     = 31;
   localparam int PAY_W     = 32;
   localparam int RUN_W     = 16;
   localparam int CSR_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CNT_W     = 6;

   localparam logic [KEY_W-1:0] SENTINEL_KEY = '1;
   localparam logic [RUN_W-1:0] RUN_MAX      = '1;
   localparam logic [CSR_W-1:0] MEM_SIZE_RST = 5'd16;
   localparam logic [CSR_W-1:0] RES_LIM_RST  = 5'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MEM_SIZE  = 2'd0,
      CSR_RES_LIMIT = 2'd1
   } csr_idx_type;

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_END    = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACT,
      ST_LOAD
   } back_state_type;

   typedef enum logic [1:0] {
      PUR_PICK,
      PUR_FIRST,
      PUR_FLUSH
   } purpose_type;

   typedef enum logic [1:0] {
      MODE_REC,
      MODE_END_MEM,
      MODE_END_RES
   } mode_type;

   typedef struct packed {
      logic             op;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } item_type;

   typedef struct packed {
      logic [CNT_W-1:0] mem_cnt;
      logic [CNT_W-1:0] res_cnt;
      logic             idle;
   } status_type;

endpackage

FILE: rtl/nsrg_if.sv
interface nsrg_req_if import nsrg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             op;
   logic [KEY_W-1:0] key;
   logic [PAY_W-1:0] payload;

   modport source (output valid, output op, output key, output payload, input ready);
   modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

interface nsrg_rsp_if import nsrg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] out_key;
   logic [PAY_W-1:0] out_payload;
   logic [RUN_W-1:0] run_number;
   logic             is_sentinel;
   logic             last;

   modport source (output valid, output out_key, output out_payload, output run_number,
                   output is_sentinel, output last, input ready);
   modport sink   (input valid, input out_key, input out_payload, input run_number,
                   input is_sentinel, input last, output ready);
endinterface

FILE: rtl/natural_selection_run_generator.sv
// Natural-selection run generator.
// req_ch: valid/ready request channel carrying op (record or end of input),
//   key and payload. A two-entry queue takes requests while the engine works.
// rsp_ch: valid/ready result channel; each result carries a key (all ones
//   for a run-closing sentinel), payload, run number, sentinel and last flags.
// csr_*: write-only registers memory_size (index 0) and reservoir_limit
//   (index 1); writes take effect only while memory and reservoir are empty.
// Flow: a request passes through the queue into the engine; a record that does
//   not fill the memory is then done. Once the memory is full, the first
//   result needs a fill, a scan of all MEM_DEPTH slots at one slot per cycle,
//   and a registered result; each further result of a flush needs another
//   scan, and a reservoir reload first copies its records into memory one at
//   a time. The engine takes the next request only from idle, so the slot
//   scan sets the rate.
// A finished result waits in an output register; while the receiver stalls
//   the engine holds at its next result and the queue keeps taking requests
//   until full.
// Reset clears the memory, reservoir and queue counts, valid bits, run number and last key, and sets
//   both registers to 16. There is no clearing pass.
module natural_selection_run_generator import nsrg_pkg::*; #(
   parameter int MEM_DEPTH    = MEM_DEPTH_DEF,
   parameter int RES_DEPTH    = RES_DEPTH_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   nsrg_req_if.sink             req_ch,
   nsrg_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

`include "natural_selection_run_generator_defines.svh"

   item_type   q_item;
   logic       q_valid;
   logic       q_pop;
   status_type stat;

   nsrg_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   nsrg_back #(
      .MEM_DEPTH    (MEM_DEPTH),
      .RES_DEPTH    (RES_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_item    (q_item),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_ch    (rsp_ch),
      .stat      (stat)
   );

   `NSRG_ASSERT_IMPL(a_res_bound, 1'b1, stat.res_cnt <= CNT_W'(RES_DEPTH))
   `NSRG_ASSERT_IMPL(a_mem_bound, 1'b1, stat.mem_cnt <= CNT_W'(MEM_DEPTH))
   `NSRG_ASSERT_IMPL(a_sentinel, rsp_ch.valid && rsp_ch.is_sentinel, rsp_ch.out_key == SENTINEL_KEY && rsp_ch.out_payload == '0)
   `NSRG_ASSERT_NEXT(a_idle_quiet, stat.idle && rsp_ch.valid && rsp_ch.ready, !rsp_ch.valid)

endmodule

FILE: rtl/nsrg_front.sv
module nsrg_front import nsrg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   nsrg_req_if.sink       req_ch,
   output item_type       q_item,
   output logic           q_valid,
   input  logic           q_pop
);

   item_type    entry_ff [2];
   item_type    entry_in [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;
   logic        pop;

   assign req_ch.ready = (cnt_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (cnt_ff != 2'd0);
   assign pop          = q_pop && q_valid;
   assign q_item       = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = '{op: req_ch.op, key: req_ch.key, payload: req_ch.payload};
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: rtl/nsrg_back.sv
module nsrg_back import nsrg_pkg::*; #(
   parameter int MEM_DEPTH    = MEM_DEPTH_DEF,
   parameter int RES_DEPTH    = RES_DEPTH_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  item_type             q_item,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   nsrg_rsp_if.source           rsp_ch,
   output status_type           stat
);

   localparam int IW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int RIW = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
   localparam int SPW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
   localparam int CAP = (MEM_DEPTH < RES_DEPTH) ? MEM_DEPTH : RES_DEPTH;

   back_state_type state_ff, state_in;
   purpose_type    purpose_ff, purpose_in;
   mode_type       mode_ff, mode_in;

   logic [KEY_W-1:0] slot_key_ff [MEM_DEPTH];
   logic [KEY_W-1:0] slot_key_in [MEM_DEPTH];
   logic [SPW-1:0]   slot_pay_ff [MEM_DEPTH];
   logic [SPW-1:0]   slot_pay_in [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] slot_vld_ff, slot_vld_in;
   logic [KEY_W-1:0] res_key_ff [RES_DEPTH];
   logic [KEY_W-1:0] res_key_in [RES_DEPTH];
   logic [SPW-1:0]   res_pay_ff [RES_DEPTH];
   logic [SPW-1:0]   res_pay_in [RES_DEPTH];

   logic [CNT_W-1:0] mem_cnt_ff, mem_cnt_in;
   logic [CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic [CNT_W-1:0] ld_ff, ld_in;
   logic [KEY_W-1:0] last_key_ff, last_key_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic [CSR_W-1:0] mem_size_ff, mem_size_in;
   logic [CSR_W-1:0] res_lim_ff, res_lim_in;

   logic [IW-1:0]    scan_idx_ff, scan_idx_in;
   logic             found_ff, found_in;
   logic [IW-1:0]    best_idx_ff, best_idx_in;
   logic [KEY_W-1:0] best_key_ff, best_key_in;
   logic [SPW-1:0]   best_pay_ff, best_pay_in;

   logic             rsp_vld_ff, rsp_vld_in;
   logic [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [PAY_W-1:0] rsp_pay_ff, rsp_pay_in;
   logic [RUN_W-1:0] rsp_run_ff, rsp_run_in;
   logic             rsp_sent_ff, rsp_sent_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0] eff_mem, eff_res, cap_res, res_after;
   logic             free_found;
   logic [IW-1:0]    free_idx;
   logic             can_emit, pick_ok, scan_end, ld_ok;
   logic             act_emit, act_sent, act_last, act_go;
   logic [RUN_W-1:0] run_adv;

   // effective register values
   always_comb begin
      eff_mem = CNT_W'(mem_size_ff);
      if (eff_mem == '0) eff_mem = CNT_W'(1);
      if (eff_mem > CNT_W'(MEM_DEPTH)) eff_mem = CNT_W'(MEM_DEPTH);
      cap_res = (eff_mem < CNT_W'(CAP)) ? eff_mem : CNT_W'(CAP);
      eff_res = CNT_W'(res_lim_ff);
      if (eff_res == '0) eff_res = CNT_W'(1);
      if (eff_res > cap_res) eff_res = cap_res;
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < MEM_DEPTH; i++) begin
         if (!free_found && !slot_vld_ff[i] && (CNT_W'(i) < eff_mem)) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   assign can_emit  = !rsp_vld_ff || rsp_ch.ready;
   assign pick_ok   = best_key_ff >= last_key_ff;
   assign scan_end  = scan_idx_ff == IW'(MEM_DEPTH - 1);
   assign ld_ok     = (ld_ff < res_cnt_ff) && (ld_ff < CNT_W'(MEM_DEPTH));
   assign res_after = res_cnt_ff + CNT_W'(res_cnt_ff < CNT_W'(RES_DEPTH));
   assign run_adv   = (run_ff != RUN_MAX) ? run_ff + RUN_W'(1) : run_ff;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      act_emit = 1'b0;
      act_sent = 1'b0;
      act_last = 1'b0;
      case (purpose_ff)
         PUR_PICK: begin
            act_emit = found_ff && pick_ok;
            act_last = 1'b1;
         end
         PUR_FIRST: begin
            act_emit = found_ff;
            act_last = 1'b1;
         end
         PUR_FLUSH: begin
            act_emit = 1'b1;
            act_sent = !found_ff;
            act_last = !found_ff && ((mode_ff == MODE_END_RES) ||
                       ((mode_ff == MODE_END_MEM) && (res_cnt_ff == '0)));
         end
         default: begin
            act_emit = 1'b0;
         end
      endcase
   end

   assign act_go = !act_emit || can_emit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.op == OP_RECORD) begin
                  if (free_found && (mem_cnt_ff + CNT_W'(1) >= eff_mem)) state_in = ST_SCAN;
               end else if (mem_cnt_ff != '0) begin
                  state_in = ST_SCAN;
               end else if (res_cnt_ff != '0) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end) state_in = ST_ACT;
         end
         ST_ACT: begin
            if (act_go) begin
               case (purpose_ff)
                  PUR_PICK: begin
                     if (found_ff && !pick_ok && (res_after >= eff_res)) state_in = ST_SCAN;
                     else state_in = ST_IDLE;
                  end
                  PUR_FLUSH: begin
                     if (found_ff) state_in = ST_SCAN;
                     else if (mode_ff == MODE_REC) state_in = ST_LOAD;
                     else if ((mode_ff == MODE_END_MEM) && (res_cnt_ff != '0)) state_in = ST_LOAD;
                     else state_in = ST_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            if (!ld_ok) state_in = ST_SCAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      purpose_in  = purpose_ff;
      mode_in     = mode_ff;
      slot_key_in = slot_key_ff;
      slot_pay_in = slot_pay_ff;
      slot_vld_in = slot_vld_ff;
      res_key_in  = res_key_ff;
      res_pay_in  = res_pay_ff;
      mem_cnt_in  = mem_cnt_ff;
      res_cnt_in  = res_cnt_ff;
      ld_in       = ld_ff;
      last_key_in = last_key_ff;
      run_in      = run_ff;
      mem_size_in = mem_size_ff;
      res_lim_in  = res_lim_ff;
      scan_idx_in = scan_idx_ff;
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_key_in = best_key_ff;
      best_pay_in = best_pay_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_ch.ready;
      rsp_key_in  = rsp_key_ff;
      rsp_pay_in  = rsp_pay_ff;
      rsp_run_in  = rsp_run_ff;
      rsp_sent_in = rsp_sent_ff;
      rsp_last_in = rsp_last_ff;

      if (csr_we && (mem_cnt_ff == '0) && (res_cnt_ff == '0)) begin
         case (csr_index)
            CSR_MEM_SIZE:  mem_size_in = csr_wdata;
            CSR_RES_LIMIT: res_lim_in  = csr_wdata;
            default:       mem_size_in = mem_size_ff;
         endcase
      end

      if ((state_ff != ST_SCAN) && !((state_ff == ST_ACT) && !act_go)) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.op == OP_RECORD) begin
                  if (free_found) begin
                     slot_key_in[free_idx] = q_item.key;
                     slot_pay_in[free_idx] = q_item.payload[SPW-1:0];
                     slot_vld_in[free_idx] = 1'b1;
                     mem_cnt_in = mem_cnt_ff + CNT_W'(1);
                     purpose_in = PUR_PICK;
                  end
               end else if (mem_cnt_ff != '0) begin
                  purpose_in = PUR_FLUSH;
                  mode_in    = MODE_END_MEM;
               end else if (res_cnt_ff != '0) begin
                  run_in  = run_adv;
                  ld_in   = '0;
                  mode_in = MODE_END_RES;
               end else begin
                  last_key_in = '0;
                  run_in      = '0;
               end
            end
         end
         ST_SCAN: begin
            scan_idx_in = scan_idx_ff + IW'(1);
            if (slot_vld_ff[scan_idx_ff] &&
                (!found_ff || (slot_key_ff[scan_idx_ff] < best_key_ff))) begin
               found_in    = 1'b1;
               best_idx_in = scan_idx_ff;
               best_key_in = slot_key_ff[scan_idx_ff];
               best_pay_in = slot_pay_ff[scan_idx_ff];
            end
         end
         ST_ACT: begin
            if (act_go) begin
               if (act_emit) begin
                  rsp_vld_in  = 1'b1;
                  rsp_key_in  = act_sent ? SENTINEL_KEY : best_key_ff;
                  rsp_pay_in  = act_sent ? '0 : PAY_W'(best_pay_ff);
                  rsp_run_in  = run_ff;
                  rsp_sent_in = act_sent;
                  rsp_last_in = act_last;
               end
               if (found_ff) begin
                  slot_vld_in[best_idx_ff] = 1'b0;
                  if (mem_cnt_ff != '0) mem_cnt_in = mem_cnt_ff - CNT_W'(1);
               end
               case (purpose_ff)
                  PUR_PICK: begin
                     if (found_ff && pick_ok) begin
                        last_key_in = best_key_ff;
                     end else if (found_ff) begin
                        if (res_cnt_ff < CNT_W'(RES_DEPTH)) begin
                           res_key_in[res_cnt_ff[RIW-1:0]] = best_key_ff;
                           res_pay_in[res_cnt_ff[RIW-1:0]] = best_pay_ff;
                        end
                        res_cnt_in = res_after;
                        purpose_in = PUR_FLUSH;
                        mode_in    = MODE_REC;
                     end
                  end
                  PUR_FIRST: begin
                     if (found_ff) last_key_in = best_key_ff;
                  end
                  PUR_FLUSH: begin
                     if (!found_ff) begin
                        if (mode_ff == MODE_REC) begin
                           run_in = run_adv;
                           ld_in  = '0;
                        end else if ((mode_ff == MODE_END_MEM) && (res_cnt_ff != '0)) begin
                           run_in  = run_adv;
                           ld_in   = '0;
                           mode_in = MODE_END_RES;
                        end else begin
                           last_key_in = '0;
                           run_in      = '0;
                        end
                     end
                  end
                  default: begin
                     purpose_in = purpose_ff;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            if (ld_ok) begin
               slot_key_in[ld_ff[IW-1:0]] = res_key_ff[ld_ff[RIW-1:0]];
               slot_pay_in[ld_ff[IW-1:0]] = res_pay_ff[ld_ff[RIW-1:0]];
               slot_vld_in[ld_ff[IW-1:0]] = 1'b1;
               ld_in = ld_ff + CNT_W'(1);
            end else begin
               mem_cnt_in = ld_ff;
               res_cnt_in = '0;
               purpose_in = (mode_ff == MODE_REC) ? PUR_FIRST : PUR_FLUSH;
            end
         end
         default: begin
            purpose_in = purpose_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_key_ff <= slot_key_in;
      slot_pay_ff <= slot_pay_in;
      res_key_ff  <= res_key_in;
      res_pay_ff  <= res_pay_in;
      ld_ff       <= ld_in;
      scan_idx_ff <= scan_idx_in;
      best_idx_ff <= best_idx_in;
      best_key_ff <= best_key_in;
      best_pay_ff <= best_pay_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_pay_ff  <= rsp_pay_in;
      rsp_run_ff  <= rsp_run_in;
      rsp_sent_ff <= rsp_sent_in;
      rsp_last_ff <= rsp_last_in;
      purpose_ff  <= purpose_in;
      mode_ff     <= mode_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         slot_vld_ff <= '0;
         mem_cnt_ff  <= '0;
         res_cnt_ff  <= '0;
         last_key_ff <= '0;
         run_ff      <= '0;
         mem_size_ff <= MEM_SIZE_RST;
         res_lim_ff  <= RES_LIM_RST;
         found_ff    <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         slot_vld_ff <= slot_vld_in;
         mem_cnt_ff  <= mem_cnt_in;
         res_cnt_ff  <= res_cnt_in;
         last_key_ff <= last_key_in;
         run_ff      <= run_in;
         mem_size_ff <= mem_size_in;
         res_lim_ff  <= res_lim_in;
         found_ff    <= found_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.out_key     = rsp_key_ff;
   assign rsp_ch.out_payload = rsp_pay_ff;
   assign rsp_ch.run_number  = rsp_run_ff;
   assign rsp_ch.is_sentinel = rsp_sent_ff;
   assign rsp_ch.last        = rsp_last_ff;

   assign stat = '{mem_cnt: mem_cnt_ff, res_cnt: res_cnt_ff, idle: state_ff == ST_IDLE};

endmodule
